[rtl/qst_pkg.sv]
// Package for the query string tokenizer: payload structs, phase encoding,
// delimiter bytes and default sizes.
// No dependencies.
package qst_pkg;

  localparam int CH_W  = 8;
  localparam int OFS_W = 12;
  localparam int CNT_W = 5;

  localparam int MAX_PAIRS_DEF    = 20;
  localparam int MAX_PATH_LEN_DEF = 4096;

  localparam logic [CH_W-1:0] CH_QUESTION = 8'h3F;
  localparam logic [CH_W-1:0] CH_EQUALS   = 8'h3D;
  localparam logic [CH_W-1:0] CH_AMP      = 8'h26;

  typedef enum logic [1:0] {
    PH_SEEK  = 2'd0,
    PH_KEY   = 2'd1,
    PH_VALUE = 2'd2,
    PH_DONE  = 2'd3
  } phase_t;

  typedef struct packed {
    logic [CH_W-1:0] ch;
    logic            last;
  } qst_in_t;

  typedef struct packed {
    logic             pair_valid;
    logic [CNT_W-1:0] pair_index;
    logic [OFS_W-1:0] key_offset;
    logic [OFS_W-1:0] key_length;
    logic [OFS_W-1:0] value_offset;
    logic [OFS_W-1:0] value_length;
    logic             end_of_path;
    logic [CNT_W-1:0] pair_count;
  } qst_out_t;

endpackage

[rtl/query_string_tokenizer.sv]
// A result is registered in the cycle after the byte that causes it is accepted.
// Throughput: one byte per cycle while in_ready is high; the phase update, position counter and span
// subtractions all settle between the state registers and the result register.
// in_ready is high while the result register is empty or being drained.
// Reset (rst_n, synchronous, active low) returns to the seek phase and empties the output.
// Depends on qst_pkg.
module query_string_tokenizer #(
  parameter int MAX_PAIRS    = qst_pkg::MAX_PAIRS_DEF,
  parameter int MAX_PATH_LEN = qst_pkg::MAX_PATH_LEN_DEF
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_ready,
  input  qst_pkg::qst_in_t  in_data,
  output logic              out_valid,
  input  logic              out_ready,
  output qst_pkg::qst_out_t out_data
);
  import qst_pkg::*;

  localparam int PW    = $clog2(MAX_PATH_LEN);
  localparam int EXT_W = (PW > OFS_W) ? PW : OFS_W;

  phase_t           phase_r, phase_nxt;
  logic [PW-1:0]    position_r, position_nxt;
  logic [PW-1:0]    seg_start_r, seg_start_nxt;
  logic [PW-1:0]    key_ofs_r, key_ofs_nxt;
  logic [PW-1:0]    key_len_r, key_len_nxt;
  logic [CNT_W-1:0] pairs_r, pairs_nxt;
  logic             out_valid_r, out_valid_nxt;
  qst_out_t         out_data_r, out_data_nxt;

  logic             accept;
  logic [PW-1:0]    pos_inc;
  logic             have_pair;
  logic [CNT_W-1:0] pair_idx;
  logic [PW-1:0]    val_len;
  logic             at_limit;

  function automatic logic [PW-1:0] inc_wrap(input logic [PW-1:0] p);
    return (p == PW'(MAX_PATH_LEN - 1)) ? '0 : p + PW'(1);
  endfunction

  // Distance from 'from' to 'to' modulo the path length.
  function automatic logic [PW-1:0] span(input logic [PW-1:0] from, input logic [PW-1:0] to);
    logic [PW:0] diff;
    diff = {1'b0, to} - {1'b0, from};
    if (diff[PW]) begin
      diff = diff + (PW+1)'(MAX_PATH_LEN);
    end
    return diff[PW-1:0];
  endfunction

  function automatic logic [OFS_W-1:0] to_ofs(input logic [PW-1:0] x);
    logic [EXT_W-1:0] e;
    e = EXT_W'(x);
    return e[OFS_W-1:0];
  endfunction

  assign in_ready  = out_ready || !out_valid_r;
  assign accept    = in_valid && in_ready;
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  assign pos_inc  = inc_wrap(position_r);
  assign at_limit = (pairs_r >= CNT_W'(MAX_PAIRS - 1));

  always_comb begin
    phase_nxt     = phase_r;
    seg_start_nxt = seg_start_r;
    key_ofs_nxt   = key_ofs_r;
    key_len_nxt   = key_len_r;
    pairs_nxt     = pairs_r;
    have_pair     = 1'b0;
    pair_idx      = pairs_r;
    val_len       = '0;

    unique case (phase_r)
      PH_SEEK: begin
        if (in_data.ch == CH_QUESTION) begin
          seg_start_nxt = pos_inc;
          phase_nxt     = PH_KEY;
        end
      end
      PH_KEY: begin
        if (in_data.ch == CH_EQUALS) begin
          key_ofs_nxt   = seg_start_r;
          key_len_nxt   = span(seg_start_r, position_r);
          seg_start_nxt = pos_inc;
          phase_nxt     = PH_VALUE;
        end
      end
      PH_VALUE: begin
        if (in_data.ch == CH_AMP) begin
          if (at_limit) begin
            phase_nxt = PH_DONE;
          end else begin
            have_pair     = 1'b1;
            val_len       = span(seg_start_r, position_r);
            pairs_nxt     = pairs_r + CNT_W'(1);
            seg_start_nxt = pos_inc;
            phase_nxt     = PH_KEY;
          end
        end else if (in_data.last) begin
          have_pair = 1'b1;
          val_len   = span(seg_start_r, pos_inc);
          pairs_nxt = pairs_r + CNT_W'(1);
        end
      end
      PH_DONE: begin
      end
      default: begin
      end
    endcase

    out_data_nxt              = out_data_r;
    out_data_nxt.pair_valid   = have_pair;
    out_data_nxt.pair_index   = have_pair ? pair_idx : '0;
    out_data_nxt.key_offset   = have_pair ? to_ofs(key_ofs_nxt) : '0;
    out_data_nxt.key_length   = have_pair ? to_ofs(key_len_nxt) : '0;
    out_data_nxt.value_offset = have_pair ? to_ofs(seg_start_r) : '0;
    out_data_nxt.value_length = have_pair ? to_ofs(val_len) : '0;
    out_data_nxt.end_of_path  = in_data.last;
    out_data_nxt.pair_count   = pairs_nxt;

    position_nxt = pos_inc;
    // Re-arm for the next path after the final byte.
    if (in_data.last) begin
      phase_nxt     = PH_SEEK;
      position_nxt  = '0;
      seg_start_nxt = '0;
      key_ofs_nxt   = '0;
      key_len_nxt   = '0;
      pairs_nxt     = '0;
    end

    out_valid_nxt = out_valid_r && !out_ready;
    if (accept && (have_pair || in_data.last)) begin
      out_valid_nxt = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r     <= PH_SEEK;
      position_r  <= '0;
      seg_start_r <= '0;
      key_ofs_r   <= '0;
      key_len_r   <= '0;
      pairs_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
      if (accept) begin
        phase_r     <= phase_nxt;
        position_r  <= position_nxt;
        seg_start_r <= seg_start_nxt;
        key_ofs_r   <= key_ofs_nxt;
        key_len_r   <= key_len_nxt;
        pairs_r     <= pairs_nxt;
      end
    end
  end

  // Result payload: load only when a new transaction produces a result.
  always_ff @(posedge clk) begin
    if (accept && (have_pair || in_data.last)) begin
      out_data_r <= out_data_nxt;
    end
  end

endmodule

[rtl/qst_checker.sv]
// Port-level checks for the query string tokenizer, bound to the top level.
// Depends on qst_pkg and query_string_tokenizer.
module qst_checker (
  input logic              clk,
  input logic              rst_n,
  input logic              in_ready,
  input logic              out_valid,
  input logic              out_ready,
  input qst_pkg::qst_out_t out_data
);
  import qst_pkg::*;

  // Hold a stalled result.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_data))
    else $error("stalled result changed or dropped");

  a_ready_free: assert property (@(posedge clk) disable iff (!rst_n)
    !in_ready |-> out_valid)
    else $error("input stalled with empty result register");

  a_end_only: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_data.pair_valid |-> out_data.end_of_path &&
      out_data.pair_index == '0 && out_data.key_offset == '0 &&
      out_data.key_length == '0 && out_data.value_offset == '0 &&
      out_data.value_length == '0)
    else $error("result without a pair is not a clean end result");

  a_count_tracks_index: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.pair_valid |->
      out_data.pair_count == out_data.pair_index + CNT_W'(1))
    else $error("pair count does not follow pair index");

  // A fresh pair after an end result restarts at index zero.
  a_index_restart: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_ready && out_data.end_of_path ##1
      out_valid && out_data.pair_valid && !out_data.end_of_path
      |-> out_data.pair_index == '0)
    else $error("pair index did not restart after end of path");

endmodule

bind query_string_tokenizer qst_checker u_qst_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_ready  (in_ready),
  .out_valid (out_valid),
  .out_ready (out_ready),
  .out_data  (out_data)
);
